// ===== rtl/ntc_temperature_interp_averager_core_assert.svh =====
// assertion macros shared by the ntc_tia rtl modules
// expects clk_i and rst_ni in the scope of the including module
`ifndef NTC_TEMPERATURE_INTERP_AVERAGER_CORE_ASSERT_SVH
`define NTC_TEMPERATURE_INTERP_AVERAGER_CORE_ASSERT_SVH

// plain property, checked outside reset
`define NTC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// implication, checked outside reset
`define NTC_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

// ===== rtl/ntc_tia_pkg.sv =====
// types, constants and derived widths for the ntc temperature converter
// no dependencies; used by every rtl module of the block
package ntc_tia_pkg;

  localparam int unsigned TablePoints      = 12;
  localparam int unsigned SamplesPerResult = 8;
  localparam int unsigned AdcBits          = 10;

  localparam int unsigned Spacing    = 100;
  localparam int unsigned FirstPoint = 50;
  localparam int unsigned TableDepth = 2 * TablePoints;
  localparam int unsigned HiCount    = Spacing * (TablePoints - 1);

  localparam int unsigned OffsetW = 10;
  localparam int unsigned TempW   = 16;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned SampleW = 10;
  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = $clog2(TableDepth);

  // offset-corrected count and its clamped form
  localparam int unsigned CW = $clog2(HiCount + 1);
  localparam int unsigned XW = (AdcBits + 2 > CW + 1) ? AdcBits + 2 : CW + 1;

  // segment index: count / spacing by reciprocal
  localparam int unsigned SegW     = $clog2(TablePoints - 1);
  localparam int unsigned SegFullW = $clog2(TablePoints);
  localparam int unsigned RecipK   = CW + 7;
  localparam int unsigned RecipC   = (2 ** RecipK + Spacing - 1) / Spacing;
  localparam int unsigned RecipCW  = $clog2(RecipC + 1);
  localparam int unsigned SegProdW = CW + RecipCW;

  // interpolation product and quotient
  localparam int unsigned DxW    = $clog2(Spacing + 1);
  localparam int unsigned DiffW  = TempW + 1;
  localparam int unsigned ProdW  = DxW + 1 + DiffW;
  localparam int unsigned MagW   = DxW + TempW;
  localparam int unsigned QK     = MagW + 7;
  localparam int unsigned QC     = (2 ** QK + Spacing - 1) / Spacing;
  localparam int unsigned QCW    = $clog2(QC + 1);
  localparam int unsigned QProdW = MagW + QCW;

  // run accumulation, average by shift
  localparam int unsigned SumW     = TempW + $clog2(SamplesPerResult);
  localparam int unsigned CntW     = $clog2(SamplesPerResult + 1);
  localparam int unsigned AvgShift = $clog2(SamplesPerResult);

  localparam logic signed [XW-1:0] XLo = XW'(FirstPoint);
  localparam logic signed [XW-1:0] XHi = XW'(HiCount);

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic {
    SENSOR_B = 1'b0,
    SENSOR_A = 1'b1
  } sensor_e;

  typedef enum logic {
    REG_OFFSET_A = 1'b0,
    REG_OFFSET_B = 1'b1
  } reg_e;

  typedef struct packed {
    cmd_e                    cmd;
    sensor_e                 sensor_sel;
    logic [IdxW-1:0]         entry_index;
    logic signed [TempW-1:0] entry_value;
    logic [SampleW-1:0]      adc_sample;
  } in_t;

  typedef struct packed {
    logic signed [TempW-1:0] temperature;
    logic                    clamped;
  } out_t;

  typedef struct packed {
    sensor_e                 sensor;
    logic                    clamp;
    logic                    first;
    logic [DxW-1:0]          dx;
    logic signed [TempW-1:0] ta;
    logic signed [TempW-1:0] tb;
  } seg_t;

  typedef struct packed {
    sensor_e                 sensor;
    logic                    clamp;
    logic signed [TempW-1:0] value;
  } samp_t;

endpackage

// ===== rtl/ntc_tia_lookup.sv =====
// input register, offset and clamp, segment select and table memory
// depends on ntc_tia_pkg and the assertion macro header
`include "ntc_temperature_interp_averager_core_assert.svh"

module ntc_tia_lookup (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  ntc_tia_pkg::in_t                            in_data_i,
  input  logic signed [ntc_tia_pkg::OffsetW-1:0]      offset_a_i,
  input  logic signed [ntc_tia_pkg::OffsetW-1:0]      offset_b_i,
  output logic                                        seg_valid_o,
  input  logic                                        seg_ready_i,
  output ntc_tia_pkg::seg_t                           seg_o
);

  logic                                      v1_q;
  ntc_tia_pkg::in_t                          s1_q;
  logic                                      v2_q;
  logic                                      en2;
  logic                                      is_sample;
  logic                                      is_load;
  logic signed [ntc_tia_pkg::OffsetW-1:0]    offset;
  logic signed [ntc_tia_pkg::XW-1:0]         x;
  logic                                      clamp_lo;
  logic                                      clamp_hi;
  logic [ntc_tia_pkg::CW-1:0]                xc;
  logic [ntc_tia_pkg::CW-1:0]                a1;
  logic [ntc_tia_pkg::SegProdW-1:0]          seg_prod;
  logic [ntc_tia_pkg::SegFullW-1:0]          seg_full;
  logic [ntc_tia_pkg::SegW-1:0]              seg;
  logic                                      first;
  logic [ntc_tia_pkg::AddrW-1:0]             base;
  logic [ntc_tia_pkg::AddrW-1:0]             rd_a;
  logic [ntc_tia_pkg::AddrW-1:0]             rd_b;
  logic [ntc_tia_pkg::AddrW-1:0]             wr_a;
  logic                                      wr_en;
  logic                                      rd_en;
  logic signed [ntc_tia_pkg::TempW-1:0]      lut_mem [ntc_tia_pkg::TableDepth];
  logic signed [ntc_tia_pkg::TempW-1:0]      ta_q;
  logic signed [ntc_tia_pkg::TempW-1:0]      tb_q;
  ntc_tia_pkg::sensor_e                      sensor_q;
  logic                                      clamp_q;
  logic                                      first_q;
  logic [ntc_tia_pkg::DxW-1:0]               dx_q;

  assign en2        = !v2_q || seg_ready_i;
  assign in_ready_o = !v1_q || en2;
  assign is_sample  = v1_q && (s1_q.cmd == ntc_tia_pkg::CMD_SAMPLE);
  assign is_load    = v1_q && (s1_q.cmd == ntc_tia_pkg::CMD_LOAD);

  always_comb begin
    offset   = (s1_q.sensor_sel == ntc_tia_pkg::SENSOR_A) ? offset_a_i : offset_b_i;
    x        = ntc_tia_pkg::XW'($signed({1'b0, s1_q.adc_sample[ntc_tia_pkg::AdcBits-1:0]}))
             + ntc_tia_pkg::XW'(offset);
    clamp_lo = x < ntc_tia_pkg::XLo;
    clamp_hi = x > ntc_tia_pkg::XHi;
    if (clamp_lo) begin
      xc = ntc_tia_pkg::CW'(ntc_tia_pkg::FirstPoint);
    end else if (clamp_hi) begin
      xc = ntc_tia_pkg::CW'(ntc_tia_pkg::HiCount);
    end else begin
      xc = ntc_tia_pkg::CW'(x);
    end
    seg_prod = ntc_tia_pkg::SegProdW'(xc) * ntc_tia_pkg::SegProdW'(ntc_tia_pkg::RecipC);
    seg_full = ntc_tia_pkg::SegFullW'(seg_prod >> ntc_tia_pkg::RecipK);
    if (seg_full > ntc_tia_pkg::SegFullW'(ntc_tia_pkg::TablePoints - 2)) begin
      seg = ntc_tia_pkg::SegW'(ntc_tia_pkg::TablePoints - 2);
    end else begin
      seg = ntc_tia_pkg::SegW'(seg_full);
    end
    first = (seg == '0);
    a1    = first ? ntc_tia_pkg::CW'(ntc_tia_pkg::FirstPoint)
                  : ntc_tia_pkg::CW'(seg * ntc_tia_pkg::Spacing);
    base  = (s1_q.sensor_sel == ntc_tia_pkg::SENSOR_A)
          ? ntc_tia_pkg::AddrW'(ntc_tia_pkg::TablePoints) : '0;
    rd_a  = base + ntc_tia_pkg::AddrW'(seg);
    rd_b  = rd_a + ntc_tia_pkg::AddrW'(1);
    wr_a  = base + ntc_tia_pkg::AddrW'(s1_q.entry_index);
    wr_en = en2 && is_load && (32'(s1_q.entry_index) < ntc_tia_pkg::TablePoints);
    rd_en = en2 && is_sample;
  end

  // table store, entries hold nothing until loaded
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lut_mem[wr_a] <= s1_q.entry_value;
    end
    if (rd_en) begin
      ta_q <= lut_mem[rd_a];
      tb_q <= lut_mem[rd_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= is_sample;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
    if (rd_en) begin
      sensor_q <= s1_q.sensor_sel;
      clamp_q  <= clamp_lo || clamp_hi;
      first_q  <= first;
      dx_q     <= ntc_tia_pkg::DxW'(xc - a1);
    end
  end

  assign seg_valid_o  = v2_q;
  assign seg_o.sensor = sensor_q;
  assign seg_o.clamp  = clamp_q;
  assign seg_o.first  = first_q;
  assign seg_o.dx     = dx_q;
  assign seg_o.ta     = ta_q;
  assign seg_o.tb     = tb_q;

  `NTC_ASSERT_IMPL(stall_needs_full_a, !in_ready_o, v1_q && v2_q && !seg_ready_i, "input stalled with a free stage")

endmodule

// ===== rtl/ntc_tia_interp.sv =====
// interpolation between two table points: product stage, then reciprocal divide
// depends on ntc_tia_pkg
module ntc_tia_interp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                seg_valid_i,
  output logic                seg_ready_o,
  input  ntc_tia_pkg::seg_t   seg_i,
  output logic                samp_valid_o,
  input  logic                samp_ready_i,
  output ntc_tia_pkg::samp_t  samp_o
);

  logic                                      v3_q;
  logic                                      v4_q;
  logic                                      en3;
  logic                                      en4;
  logic signed [ntc_tia_pkg::DiffW-1:0]      diff;
  logic signed [ntc_tia_pkg::ProdW-1:0]      num_d;
  logic signed [ntc_tia_pkg::ProdW-1:0]      num_q;
  ntc_tia_pkg::sensor_e                      sensor3_q;
  logic                                      clamp3_q;
  logic                                      first3_q;
  logic signed [ntc_tia_pkg::TempW-1:0]      ta3_q;
  logic                                      neg;
  logic [ntc_tia_pkg::MagW-1:0]              mag;
  logic [ntc_tia_pkg::MagW-1:0]              mag2;
  logic [ntc_tia_pkg::QProdW-1:0]            q_prod;
  logic [ntc_tia_pkg::TempW-1:0]             q;
  logic signed [ntc_tia_pkg::TempW:0]        qs;
  logic signed [ntc_tia_pkg::TempW-1:0]      value_d;
  ntc_tia_pkg::samp_t                        samp_q;

  assign en4         = !v4_q || samp_ready_i;
  assign en3         = !v3_q || en4;
  assign seg_ready_o = en3;

  always_comb begin
    diff  = ntc_tia_pkg::DiffW'(seg_i.tb) - ntc_tia_pkg::DiffW'(seg_i.ta);
    num_d = ntc_tia_pkg::ProdW'($signed({1'b0, seg_i.dx})) * ntc_tia_pkg::ProdW'(diff);
  end

  // first segment spans half the spacing, so its numerator is doubled
  always_comb begin
    neg     = num_q[ntc_tia_pkg::ProdW-1];
    mag     = ntc_tia_pkg::MagW'(neg ? -num_q : num_q);
    mag2    = first3_q ? (mag << 1) : mag;
    q_prod  = ntc_tia_pkg::QProdW'(mag2) * ntc_tia_pkg::QProdW'(ntc_tia_pkg::QC);
    q       = ntc_tia_pkg::TempW'(q_prod >> ntc_tia_pkg::QK);
    qs      = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    value_d = ntc_tia_pkg::TempW'((ntc_tia_pkg::TempW + 1)'(ta3_q) + qs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en3) begin
        v3_q <= seg_valid_i;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && seg_valid_i) begin
      num_q     <= num_d;
      sensor3_q <= seg_i.sensor;
      clamp3_q  <= seg_i.clamp;
      first3_q  <= seg_i.first;
      ta3_q     <= seg_i.ta;
    end
    if (en4 && v3_q) begin
      samp_q.sensor <= sensor3_q;
      samp_q.clamp  <= clamp3_q;
      samp_q.value  <= value_d;
    end
  end

  assign samp_valid_o = v4_q;
  assign samp_o       = samp_q;

endmodule

// ===== rtl/ntc_tia_accum.sv =====
// run accumulation per sensor, average and result register
// depends on ntc_tia_pkg and the assertion macro header
`include "ntc_temperature_interp_averager_core_assert.svh"

module ntc_tia_accum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                samp_valid_i,
  output logic                samp_ready_o,
  input  ntc_tia_pkg::samp_t  samp_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ntc_tia_pkg::out_t   out_data_o
);

  logic signed [ntc_tia_pkg::SumW-1:0]   sum_q;
  logic signed [ntc_tia_pkg::SumW-1:0]   sum_d;
  logic [ntc_tia_pkg::CntW-1:0]          cnt_q;
  logic [ntc_tia_pkg::CntW-1:0]          cnt_d;
  logic                                  clamp_q;
  logic                                  clamp_d;
  ntc_tia_pkg::sensor_e                  run_sensor_q;
  ntc_tia_pkg::sensor_e                  run_sensor_d;
  logic                                  out_valid_q;
  logic                                  out_valid_d;
  ntc_tia_pkg::out_t                     out_q;
  logic                                  consume;
  logic                                  restart;
  logic                                  done;
  logic signed [ntc_tia_pkg::SumW-1:0]   new_sum;
  logic signed [ntc_tia_pkg::SumW-1:0]   biased;
  logic [ntc_tia_pkg::CntW-1:0]          new_cnt;
  logic                                  new_clamp;
  logic signed [ntc_tia_pkg::TempW-1:0]  avg;

  assign samp_ready_o = !out_valid_q || out_ready_i;
  assign consume      = samp_valid_i && samp_ready_o;

  // a sample of the other sensor drops the partial run
  always_comb begin
    restart   = (cnt_q != '0) && (samp_i.sensor != run_sensor_q);
    new_sum   = (restart ? '0 : sum_q) + ntc_tia_pkg::SumW'(samp_i.value);
    new_cnt   = (restart ? '0 : cnt_q) + ntc_tia_pkg::CntW'(1);
    new_clamp = (restart ? 1'b0 : clamp_q) | samp_i.clamp;
    done      = new_cnt == ntc_tia_pkg::CntW'(ntc_tia_pkg::SamplesPerResult);
    biased    = new_sum + (new_sum[ntc_tia_pkg::SumW-1]
              ? ntc_tia_pkg::SumW'(ntc_tia_pkg::SamplesPerResult - 1) : '0);
    avg       = ntc_tia_pkg::TempW'(biased >>> ntc_tia_pkg::AvgShift);

    sum_d        = sum_q;
    cnt_d        = cnt_q;
    clamp_d      = clamp_q;
    run_sensor_d = run_sensor_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    if (consume) begin
      run_sensor_d = samp_i.sensor;
      if (done) begin
        sum_d       = '0;
        cnt_d       = '0;
        clamp_d     = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        sum_d   = new_sum;
        cnt_d   = new_cnt;
        clamp_d = new_clamp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q        <= '0;
      cnt_q        <= '0;
      clamp_q      <= 1'b0;
      run_sensor_q <= ntc_tia_pkg::SENSOR_B;
      out_valid_q  <= 1'b0;
    end else begin
      sum_q        <= sum_d;
      cnt_q        <= cnt_d;
      clamp_q      <= clamp_d;
      run_sensor_q <= run_sensor_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && done) begin
      out_q.temperature <= avg;
      out_q.clamped     <= new_clamp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `NTC_ASSERT(cnt_in_range_a, cnt_q < ntc_tia_pkg::CntW'(ntc_tia_pkg::SamplesPerResult), "run count past result length")
  `NTC_ASSERT_IMPL(empty_run_clear_a, cnt_q == '0, sum_q == '0 && !clamp_q, "empty run holds a sum or flag")
  `NTC_ASSERT_IMPL(result_resets_run_a, $rose(out_valid_q), cnt_q == '0, "run not restarted after result")

endmodule

// ===== rtl/ntc_temperature_interp_averager_core.sv =====
// top level of the two-sensor ntc temperature converter with averaging
// depends on ntc_tia_pkg, ntc_tia_lookup, ntc_tia_interp and ntc_tia_accum
//
// input channel in_valid_i/in_ready_o/in_data_i carries one transaction per item:
// a table load (cmd load) writes one point of the selected sensor's table, a sample
// (cmd sample) adds the sensor's offset, clamps to the table span and interpolates.
// output channel out_valid_o/out_ready_i/out_data_o carries one transaction per run
// of eight samples of one sensor: the average, truncated toward zero, and the clamp
// flag of the run. a sample of the other sensor discards a partial run.
// offsets are written over the apb port at 0x0 (battery) and 0x4 (heatsink); the user
// must write them only while no item is in flight, the block itself does not enforce it.
// an item is taken every cycle while in_ready_o is high; the result of a run passes
// from the transaction of the run's last sample through the input register, table read,
// product, divide and result registers.
// a stalled receiver keeps the result in the output register; items keep being
// taken until the four internal stages are full, then in_ready_o drops.
// reset clears the run, the offsets and all valid flags; table contents are not
// cleared and must be loaded before samples use them.
module ntc_temperature_interp_averager_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ntc_tia_pkg::in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ntc_tia_pkg::out_t  out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic signed [ntc_tia_pkg::OffsetW-1:0] offset_a_q;
  logic signed [ntc_tia_pkg::OffsetW-1:0] offset_b_q;
  ntc_tia_pkg::reg_e                      reg_sel;
  logic                                   cfg_wr;
  logic                                   seg_valid;
  logic                                   seg_ready;
  ntc_tia_pkg::seg_t                      seg;
  logic                                   samp_valid;
  logic                                   samp_ready;
  ntc_tia_pkg::samp_t                     samp;

  assign pready  = 1'b1;
  assign reg_sel = ntc_tia_pkg::reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      ntc_tia_pkg::REG_OFFSET_A: prdata = {{(ntc_tia_pkg::DataW - ntc_tia_pkg::OffsetW){1'b0}},
                                           offset_a_q};
      ntc_tia_pkg::REG_OFFSET_B: prdata = {{(ntc_tia_pkg::DataW - ntc_tia_pkg::OffsetW){1'b0}},
                                           offset_b_q};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_a_q <= '0;
      offset_b_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        ntc_tia_pkg::REG_OFFSET_A: offset_a_q <= pwdata[ntc_tia_pkg::OffsetW-1:0];
        ntc_tia_pkg::REG_OFFSET_B: offset_b_q <= pwdata[ntc_tia_pkg::OffsetW-1:0];
        default: begin
          offset_a_q <= offset_a_q;
        end
      endcase
    end
  end

  ntc_tia_lookup u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .offset_a_i  (offset_a_q),
    .offset_b_i  (offset_b_q),
    .seg_valid_o (seg_valid),
    .seg_ready_i (seg_ready),
    .seg_o       (seg)
  );

  ntc_tia_interp u_interp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seg_valid_i  (seg_valid),
    .seg_ready_o  (seg_ready),
    .seg_i        (seg),
    .samp_valid_o (samp_valid),
    .samp_ready_i (samp_ready),
    .samp_o       (samp)
  );

  ntc_tia_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .samp_valid_i (samp_valid),
    .samp_ready_o (samp_ready),
    .samp_i       (samp),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
